[design/cfmd_pkg.sv]
// Shared types and constants for the command frame to dual motor drive block.
package cfmd_pkg;

    localparam int BUF_BYTES = 4;
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);
    localparam int IDX_W     = $clog2(BUF_BYTES);
    localparam int DUTY_W    = 12;
    localparam int SCALE_W   = 5;
    localparam int PROD_W    = 8 + SCALE_W;

    localparam logic [7:0]         FRAME_END     = 8'h0A;
    localparam logic [15:0]        CODE_LEFT_Y   = 16'h4C59;
    localparam logic [15:0]        CODE_RIGHT_Y  = 16'h5259;
    localparam logic [7:0]         CENTER_VALUE  = 8'd128;
    localparam logic [7:0]         DEFLECT_BASE  = 8'd127;
    localparam logic [7:0]         STICK_RESET   = 8'd127;
    localparam logic [SCALE_W-1:0] SCALE_RESET   = 5'd16;

    typedef enum logic [0:0] {
        CFG_MOTOR_ENABLE = 1'b0,
        CFG_DUTY_SCALE   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              forward;
        logic [DUTY_W-1:0] duty;
    } drive_t;

endpackage

[design/cfmd_drive.sv]
// Stick to bridge direction and PWM duty conversion for one motor.
module cfmd_drive
    import cfmd_pkg::*;
(
    input  logic [7:0]         stick,
    input  logic [SCALE_W-1:0] scale,
    input  logic               dir_now,
    output drive_t             drive
);

    logic [7:0]        inv;
    logic [7:0]        defl;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        inv           = ~stick;
        defl          = 8'd0;
        drive.forward = dir_now;
        priority if (inv == CENTER_VALUE)
        begin
            // centered: keep direction, zero duty
            drive.forward = dir_now;
        end
        else if (inv > CENTER_VALUE)
        begin
            drive.forward = 1'b1;
            defl          = inv - DEFLECT_BASE;
        end
        else if (inv == DEFLECT_BASE)
        begin
            // reverse wrap case: clamp to zero
            drive.forward = 1'b0;
        end
        else
        begin
            drive.forward = 1'b0;
            defl          = (DEFLECT_BASE - 8'd1) - inv;
        end
        prod       = {{SCALE_W{1'b0}}, defl} * {8'd0, scale};
        drive.duty = prod[DUTY_W-1:0];
    end

endmodule

[design/command_frame_to_dual_motor_drive.sv]
// Top level: frame collector, stick decode and dual motor drive outputs.
//
// Each received byte on the slave stream yields exactly one output word with both
// bridge directions, both PWM duties and a frame-end flag. On its way out, a byte is
// stored into the frame buffer when accepted, or decodes the frame on newline,
// and marks the first stage valid; once the output side can take a word, the first
// stage runs both stick-to-duty converters (one 8x5 multiply each) and loads the
// drive registers, and the word is offered on the master side from then on. A new
// byte is accepted every cycle while the master side keeps taking words. With motor
// drive disabled, the sticks still follow frames but the drive registers hold.
module command_frame_to_dual_motor_drive
    import cfmd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,    // [0] left_forward, [12:1] left_duty,
                                           // [13] right_forward, [25:14] right_duty,
                                           // [26] frame_done, [31:27] zero
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [SCALE_W-1:0] cfg_wdata
);

    logic [7:0]         buf_reg [BUF_BYTES];
    logic [CNT_W-1:0]   count_reg;
    logic [7:0]         left_stick_reg;
    logic [7:0]         right_stick_reg;
    logic               enable_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic               s1_valid_reg;
    logic               s1_done_reg;
    logic               out_valid_reg;
    logic               done_reg;
    drive_t             left_reg;
    drive_t             right_reg;

    drive_t             left_next;
    drive_t             right_next;
    logic               out_ready;
    logic               s1_ready;
    logic               in_fire;
    logic               s1_move;
    logic               is_end;
    logic [15:0]        code;

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s_tready  = s1_ready;
    assign in_fire   = s_tvalid && s_tready;
    assign s1_move   = s1_valid_reg && out_ready;
    assign is_end    = (s_tdata == FRAME_END);
    assign code      = {buf_reg[0], buf_reg[1]};

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            scale_reg  <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MOTOR_ENABLE: enable_reg <= cfg_wdata[0];
                CFG_DUTY_SCALE:   scale_reg  <= cfg_wdata;
            endcase
        end
    end

    // frame collection and stick decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUF_BYTES; i++)
            begin
                buf_reg[i] <= 8'd0;
            end
            count_reg       <= '0;
            left_stick_reg  <= STICK_RESET;
            right_stick_reg <= STICK_RESET;
        end
        else if (in_fire)
        begin
            if (!is_end)
            begin
                // drop bytes once the buffer is full
                if (count_reg < CNT_W'(BUF_BYTES))
                begin
                    buf_reg[count_reg[IDX_W-1:0]] <= s_tdata;
                    count_reg                     <= count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (code == CODE_LEFT_Y)
                begin
                    left_stick_reg <= buf_reg[2];
                end
                if (code == CODE_RIGHT_Y)
                begin
                    right_stick_reg <= buf_reg[2];
                end
                count_reg <= '0;
            end
        end
    end

    // first stage: sticks in the registers already reflect this word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_done_reg  <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_fire;
            s1_done_reg  <= in_fire && is_end;
        end
    end

    cfmd_drive u_left_drive (
        .stick   (left_stick_reg),
        .scale   (scale_reg),
        .dir_now (left_reg.forward),
        .drive   (left_next)
    );

    cfmd_drive u_right_drive (
        .stick   (right_stick_reg),
        .scale   (scale_reg),
        .dir_now (right_reg.forward),
        .drive   (right_next)
    );

    // output stage: drive registers double as the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                done_reg <= s1_done_reg;
                if (enable_reg)
                begin
                    left_reg  <= left_next;
                    right_reg <= right_next;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, done_reg, right_reg.duty, right_reg.forward,
                       left_reg.duty, left_reg.forward};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BUF_BYTES))
        else $error("byte count above buffer size");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_end) |=> (count_reg == '0))
        else $error("newline did not clear byte count");

    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_done_reg) |-> (count_reg == '0))
        else $error("frame end in flight with nonzero count");

    a_hold_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && !enable_reg) |=> ($stable(left_reg) && $stable(right_reg)))
        else $error("drive changed while motor drive disabled");

endmodule
